/* rtl/core/mphp_pkg.sv */
// Package for the media packet header parser.
// Holds result kinds, reject codes, header constants and the queue entry type.
// No dependencies.
package mphp_pkg;

  localparam int unsigned MaxTransferDef = 1024;
  localparam int unsigned HeaderBytes    = 23;
  localparam logic [15:0] LenBias        = 16'd20;
  localparam logic [7:0]  TypeResetVal   = 8'h03;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindReject  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RejNone      = 2'd0,
    RejWrongType = 2'd1,
    RejTooLong   = 2'd2,
    RejTruncated = 2'd3
  } reject_e;

  // One result word passed from the parser front to the output back end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  sub_type;
    logic [31:0] pkt_stamp;
    logic [15:0] block_count;
    logic [31:0] block_id;
    logic [31:0] packet_id;
    logic [15:0] payload_size;
    logic        id_gap;
    logic [7:0]  payload_byte;
    logic        last;
    reject_e     reject_code;
  } result_t;

endpackage

/* rtl/core/mphp_front.sv */
// Parser front: accepts transfer words, tracks byte position and builds results.
// Depends on mphp_pkg.
module mphp_front #(
  parameter int unsigned MaxTransfer = mphp_pkg::MaxTransferDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic [11:0]       transfer_len_i,
  input  logic [7:0]        type_code_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mphp_pkg::result_t res_o
);
  import mphp_pkg::*;

  localparam logic [11:0] MaxLen  = 12'(MaxTransfer);
  localparam logic [11:0] HdrLast = 12'(HeaderBytes - 1);

  logic [11:0] pos_q, pos_d, len_q, len_d;
  logic        disc_q, disc_d;
  logic [15:0] lenf_q, lenf_d, bcnt_q, bcnt_d;
  logic [7:0]  sub_q, sub_d;
  logic [31:0] ts_q, ts_d, bid_q, bid_d, pid_q, pid_d, prev_q, prev_d;
  logic        acc, emit;
  logic [12:0] pos_inc;
  logic        at_end;
  logic [15:0] size;
  logic [31:0] pid_new;
  result_t     r;

  assign in_ready = res_ready_i;
  assign acc      = in_valid & in_ready;
  assign pos_inc  = {1'b0, pos_q} + 13'd1;
  assign at_end   = pos_inc >= {1'b0, len_q};
  assign size     = lenf_q - LenBias;
  assign pid_new  = {pid_q[23:0], data_byte_i};

  // Decode one word against position and update header registers
  always_comb begin
    pos_d = pos_q; len_d = len_q; disc_d = disc_q;
    lenf_d = lenf_q; sub_d = sub_q; ts_d = ts_q; bcnt_d = bcnt_q;
    bid_d = bid_q; pid_d = pid_q; prev_d = prev_q;
    r = '0;
    r.kind = KindReject;
    r.reject_code = RejNone;
    emit = 1'b0;
    if (acc) begin
      if (first_byte_i) begin
        pos_d = 12'd1; len_d = transfer_len_i; disc_d = 1'b0;
        r.last = 1'b1;
        if (transfer_len_i > MaxLen) begin
          emit = 1'b1; r.reject_code = RejTooLong; disc_d = 1'b1;
        end else if (data_byte_i != type_code_i) begin
          emit = 1'b1; r.reject_code = RejWrongType; disc_d = 1'b1;
        end else if (transfer_len_i <= 12'd1) begin
          emit = 1'b1; r.reject_code = RejTruncated; disc_d = 1'b1;
        end
      end else if (!disc_q) begin
        pos_d = pos_inc[11:0];
        if (pos_q < HdrLast) begin
          if (pos_q >= 12'd1 && pos_q <= 12'd2) lenf_d = {lenf_q[7:0], data_byte_i};
          else if (pos_q == 12'd8) sub_d = data_byte_i;
          else if (pos_q >= 12'd9 && pos_q <= 12'd12) ts_d = {ts_q[23:0], data_byte_i};
          else if (pos_q >= 12'd13 && pos_q <= 12'd14)
            bcnt_d = {bcnt_q[7:0], data_byte_i};
          else if (pos_q >= 12'd15 && pos_q <= 12'd18) bid_d = {bid_q[23:0], data_byte_i};
          else if (pos_q >= 12'd19) pid_d = pid_new;
          if (at_end) begin
            emit = 1'b1; r.last = 1'b1; r.reject_code = RejTruncated; disc_d = 1'b1;
          end
        end else if (pos_q == HdrLast) begin
          emit = 1'b1;
          pid_d = pid_new; prev_d = pid_new;
          r.kind = KindHeader;
          r.sub_type = sub_q; r.pkt_stamp = ts_q; r.block_count = bcnt_q;
          r.block_id = bid_q; r.packet_id = pid_new; r.payload_size = size;
          r.id_gap = (prev_q != 32'd0) && (prev_q + 32'd1 != pid_new);
          if (size == 16'd0) begin
            r.last = 1'b1; disc_d = 1'b1;
          end else if (at_end) begin
            r.last = 1'b1; r.reject_code = RejTruncated; disc_d = 1'b1;
          end
        end else begin
          emit = 1'b1;
          r.kind = KindPayload;
          r.payload_byte = data_byte_i;
          if ((pos_q - HdrLast) >= size[11:0] && size[15:12] == 4'd0) begin
            r.last = 1'b1; disc_d = 1'b1;
          end else if (at_end) begin
            r.last = 1'b1; r.reject_code = RejTruncated; disc_d = 1'b1;
          end
        end
      end
    end
  end

  // Hold control state and header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; len_q <= '0; disc_q <= 1'b1; lenf_q <= '0; sub_q <= '0;
      ts_q <= '0; bcnt_q <= '0; bid_q <= '0; pid_q <= '0; prev_q <= '0;
    end else begin
      pos_q <= pos_d; len_q <= len_d; disc_q <= disc_d; lenf_q <= lenf_d;
      sub_q <= sub_d; ts_q <= ts_d; bcnt_q <= bcnt_d; bid_q <= bid_d;
      pid_q <= pid_d; prev_q <= prev_d;
    end
  end

  assign res_valid_o = emit;
  assign res_o       = r;
endmodule

/* rtl/core/mphp_queue.sv */
// Result queue between parser front and output port.
// Depends on mphp_pkg.
module mphp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  mphp_pkg::result_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output mphp_pkg::result_t rd_data_o
);
  import mphp_pkg::*;

  localparam int unsigned Aw = $clog2(QueueDepth);

  result_t         mem_q [QueueDepth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (Aw+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Store word at write pointer
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

/* rtl/core/media_packet_header_parser.sv */
// Top level of the media packet header parser.
// Depends on mphp_pkg, mphp_front and mphp_queue.
//
// channel  direction  handshake                 payload
// in       sink       in_valid / in_ready       data_byte_i, first_byte_i, transfer_len_i
// out      source     out_valid / out_ready     kind_o .. reject_code_o
// cfg      sink       cfg_valid / cfg_ready     cfg_data_i (stream type code)
//
// One word per cycle when the queue has room; results pass through a two-entry queue.
// The front stalls only while the queue is full, so output stalls reach the input
// after two held results. Reset clears position state and sets the type code to 3.
module media_packet_header_parser #(
  parameter int unsigned MaxTransfer = mphp_pkg::MaxTransferDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [11:0] transfer_len_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind_o,
  output logic [7:0]  sub_type_o,
  output logic [31:0] pkt_stamp_o,
  output logic [15:0] block_count_o,
  output logic [31:0] block_id_o,
  output logic [31:0] packet_id_o,
  output logic [15:0] payload_size_o,
  output logic        id_gap_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  output logic [1:0]  reject_code_o
);
  import mphp_pkg::*;

  logic [7:0] type_q;
  logic       fr_valid, fr_ready;
  result_t    fr_res, q_res;

  assign cfg_ready = 1'b1;

  // Hold the stream type code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) type_q <= TypeResetVal;
    else if (cfg_valid) type_q <= cfg_data_i;
  end

  mphp_front #(.MaxTransfer(MaxTransfer)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .data_byte_i, .first_byte_i,
    .transfer_len_i, .type_code_i(type_q),
    .res_valid_o(fr_valid), .res_ready_i(fr_ready), .res_o(fr_res)
  );

  mphp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fr_valid), .wr_ready_o(fr_ready), .wr_data_i(fr_res),
    .rd_valid_o(out_valid), .rd_ready_i(out_ready), .rd_data_o(q_res)
  );

  assign kind_o         = q_res.kind;
  assign sub_type_o     = q_res.sub_type;
  assign pkt_stamp_o    = q_res.pkt_stamp;
  assign block_count_o  = q_res.block_count;
  assign block_id_o     = q_res.block_id;
  assign packet_id_o    = q_res.packet_id;
  assign payload_size_o = q_res.payload_size;
  assign id_gap_o       = q_res.id_gap;
  assign payload_byte_o = q_res.payload_byte;
  assign last_o         = q_res.last;
  assign reject_code_o  = q_res.reject_code;
endmodule

/* tb/sv/tb_media_packet_header_parser.sv */
// Testbench for media_packet_header_parser: directed and random transfers.
// Predicts every result word in the testbench and compares each whole word.
// Depends on mphp_pkg and the RTL of media_packet_header_parser.
`timescale 1ns / 100ps

module tb_media_packet_header_parser;
  import mphp_pkg::*;

  localparam int unsigned MaxLen    = 1024;
  localparam int          CycleLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte_i = '0;
  logic        first_byte_i = 1'b0;
  logic [11:0] transfer_len_i = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  sub_type_o;
  logic [31:0] pkt_stamp_o;
  logic [15:0] block_count_o;
  logic [31:0] block_id_o;
  logic [31:0] packet_id_o;
  logic [15:0] payload_size_o;
  logic        id_gap_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic [1:0]  reject_code_o;

  media_packet_header_parser i_dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .data_byte_i, .first_byte_i,
    .transfer_len_i, .cfg_valid, .cfg_ready, .cfg_data_i, .out_valid, .out_ready,
    .kind_o, .sub_type_o, .pkt_stamp_o, .block_count_o, .block_id_o, .packet_id_o,
    .payload_size_o, .id_gap_o, .payload_byte_o, .last_o, .reject_code_o
  );

  // Predictor state
  logic [7:0]  type_code;
  logic [11:0] pos, saved_len;
  logic        discarding;
  logic [15:0] len_fld, bcount;
  logic [7:0]  subtype;
  logic [31:0] stamp, blk_id, pkt_id, prev_id;

  result_t     expected_words[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  int          hold_rx = 0;
  int          rx_idle = 0;

  // Free-running clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Count cycles; abort on the limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_media_packet_header_parser NOT OK");
      $finish;
    end
  end

  function automatic result_t reject_word(reject_e code);
    result_t r;
    r = '0;
    r.kind = KindReject;
    r.last = 1'b1;
    r.reject_code = code;
    discarding = 1'b1;
    return r;
  endfunction

  // Work out the result, if any, that one accepted byte causes
  function automatic void predict_byte(logic [7:0] b, logic first, logic [11:0] tl);
    logic [11:0] p;
    logic        at_end;
    logic [15:0] size;
    result_t     r;
    if (first) begin
      pos = 12'd1;
      saved_len = tl;
      discarding = 1'b0;
      if (tl > MaxLen) expected_words.push_back(reject_word(RejTooLong));
      else if (b != type_code) expected_words.push_back(reject_word(RejWrongType));
      else if (tl <= 12'd1) expected_words.push_back(reject_word(RejTruncated));
      return;
    end
    if (discarding) return;
    p = pos;
    at_end = (13'(p) + 13'd1 >= 13'(saved_len));
    pos = p + 12'd1;
    if (p < 12'(HeaderBytes - 1)) begin
      if (p == 1 || p == 2) len_fld = {len_fld[7:0], b};
      else if (p == 8) subtype = b;
      else if (p >= 9 && p <= 12) stamp = {stamp[23:0], b};
      else if (p == 13 || p == 14) bcount = {bcount[7:0], b};
      else if (p >= 15 && p <= 18) blk_id = {blk_id[23:0], b};
      else if (p >= 19) pkt_id = {pkt_id[23:0], b};
      if (at_end) expected_words.push_back(reject_word(RejTruncated));
      return;
    end
    r = '0;
    size = len_fld - 16'd20;
    if (p == 12'(HeaderBytes - 1)) begin
      pkt_id = {pkt_id[23:0], b};
      r.kind = KindHeader;
      r.id_gap = (prev_id != 0) && (prev_id + 32'd1 != pkt_id);
      prev_id = pkt_id;
      r.sub_type = subtype;
      r.pkt_stamp = stamp;
      r.block_count = bcount;
      r.block_id = blk_id;
      r.packet_id = pkt_id;
      r.payload_size = size;
    end else begin
      r.kind = KindPayload;
      r.payload_byte = b;
    end
    if ((r.kind == KindHeader && size == 0) ||
        (r.kind == KindPayload && 17'(p) - 17'd22 >= 17'(size))) begin
      r.last = 1'b1;
      discarding = 1'b1;
    end else if (at_end) begin
      r.last = 1'b1;
      r.reject_code = RejTruncated;
      discarding = 1'b1;
    end
    expected_words.push_back(r);
  endfunction

  // Offer one word and hold it until accepted; valid drops at the next idle or drain
  task automatic send_byte(logic [7:0] b, logic first, logic [11:0] tl);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= first;
    transfer_len_i <= tl;
    do @(posedge clk_i); while (!in_ready);
    predict_byte(b, first, tl);
  endtask

  // Send a well-formed transfer; payload bytes follow len-20 with tl limiting
  task automatic send_packet(int plen, int tl, logic [31:0] pid, logic [7:0] ty);
    logic [15:0] lf;
    logic [7:0]  b;
    lf = 16'(plen + 20);
    for (int i = 0; i < tl; i++) begin
      b = 8'($urandom);
      if (i == 0) b = ty;
      else if (i == 1) b = lf[15:8];
      else if (i == 2) b = lf[7:0];
      else if (i >= 19 && i <= 22) b = pid[8*(22-i) +: 8];
      send_byte(b, i == 0, 12'(tl));
    end
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_type(logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    type_code = v;
  endtask

  // Output side: random idle bursts, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      out_ready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle <= rx_idle - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_idle <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{kind_e'(kind_o), sub_type_o, pkt_stamp_o, block_count_o, block_id_o,
              packet_id_o, payload_size_o, id_gap_o, payload_byte_o, last_o,
              reject_e'(reject_code_o)};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_byte(8'h03, 1'b1, 12'd1025);               // too long
    send_byte(8'h55, 1'b0, 12'd0);                  // ignored
    send_byte(8'h04, 1'b1, 12'd100);                // wrong type
    send_byte(8'h03, 1'b1, 12'd0);                  // ends at first byte
    send_byte(8'h03, 1'b1, 12'd1);
    send_packet(0, 10, 32'h0, 8'h03);               // ends in header
    send_packet(0, 23, 32'd5, 8'h03);               // zero payload
    send_packet(3, 26, 32'd6, 8'h03);               // in sequence
    send_packet(5, 24, 32'hFFFF_FFFF, 8'h03);       // gap, truncated in payload
    send_packet(4, 23, 32'd0, 8'h03);               // truncated on header
    send_packet(2, 30, 32'd1, 8'h03);               // trailing bytes
    send_packet(-20, 40, 32'd2, 8'h03);             // length 0 wraps
  endtask

  task automatic test_type_codes();
    write_type(8'hFF);
    send_packet(2, 25, $urandom, 8'hFF);
    send_byte(8'h03, 1'b1, 12'd30);
    write_type(8'h00);
    send_packet(1, 24, $urandom, 8'h00);
    send_byte(8'hFF, 1'b1, 12'd4095);
    write_type(8'h03);
  endtask

  task automatic test_random(int n_bytes);
    int sent;
    int plen, tl;
    logic [31:0] pid;
    sent = 0;
    pid = $urandom;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 9))
        0: begin
          send_byte(8'($urandom), 1'($urandom), 12'($urandom));
          sent++;
        end
        1: begin
          tl = $urandom_range(0, 30);
          send_packet($urandom_range(0, 8), tl, $urandom, 8'($urandom_range(2, 4)));
          sent += tl;
        end
        default: begin
          plen = ($urandom_range(0, 30) == 0) ? $urandom_range(0, 1000) :
                 $urandom_range(0, 12);
          tl = plen + 23 + $urandom_range(0, 3) - ($urandom_range(0, 5) == 0);
          if (tl > 1024) tl = 1024;
          pid = ($urandom_range(0, 4) == 0) ? $urandom : pid + 1;
          send_packet(plen, tl, pid, type_code);
          sent += tl;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_rx = 300;
    send_packet(40, 63, $urandom, type_code);
    wait_drained();
  endtask

  initial begin
    type_code = TypeResetVal;
    pos = '0; saved_len = '0; discarding = 1'b1; len_fld = '0; bcount = '0;
    subtype = '0; stamp = '0; blk_id = '0; pkt_id = '0; prev_id = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_type_codes();
    test_backpressure();
    write_type(8'h5A);
    test_random(450);
    write_type(8'h03);
    test_random(400);
    idle_on = 1'b0;
    test_random(100);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_media_packet_header_parser OK");
    end else begin
      $display("tb_media_packet_header_parser NOT OK");
    end
    $finish;
  end

endmodule
